/* hdl/pfd_pkg.sv */
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types and constants for the PPM frame decoder: field widths,
// configuration register indexes, reset defaults and flight mode codes.
// ----------------------------------------------------------------------------
package pfd_pkg;

  // field widths
  localparam int unsigned TimeW = 32;
  localparam int unsigned ChanW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // channels buffered before the mode channel closes the frame
  localparam int unsigned NumStored = 5;
  localparam int unsigned CountW = $clog2(NumStored + 1);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SYNC_THRESHOLD = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MODE_HIGH_LIMIT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MODE_LOW_LIMIT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SWITCH_THRESHOLD = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_VALID_MIN = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_VALID_MAX = 3'd5;

  // configuration reset defaults
  localparam logic [ChanW-1:0] SyncThresholdRst = 16'd10000;
  localparam logic [ChanW-1:0] ModeHighLimitRst = 16'd1600;
  localparam logic [ChanW-1:0] ModeLowLimitRst = 16'd1400;
  localparam logic [ChanW-1:0] SwitchThresholdRst = 16'd1500;
  localparam logic [ChanW-1:0] ValidMinRst = 16'd1000;
  localparam logic [ChanW-1:0] ValidMaxRst = 16'd2000;

  // flight mode codes
  typedef enum logic [1:0] {
    FM_HIGH = 2'd0,
    FM_MID  = 2'd1,
    FM_LOW  = 2'd2
  } flight_mode_e;

endpackage

/* hdl/pfd_edge_if.sv */
// ----------------------------------------------------------------------------
// pfd_edge_if
// Valid/ready channel carrying one falling-edge timestamp per word.
// ----------------------------------------------------------------------------
interface pfd_edge_if;

  logic                           valid;
  logic                           ready;
  logic [pfd_pkg::TimeW-1:0]      edge_time_us;

  modport source (output valid, output edge_time_us, input ready);
  modport sink   (input valid, input edge_time_us, output ready);

endinterface

/* hdl/pfd_frame_if.sv */
// ----------------------------------------------------------------------------
// pfd_frame_if
// Valid/ready channel carrying one decoded PPM frame per word.
// ----------------------------------------------------------------------------
interface pfd_frame_if;

  logic                      valid;
  logic                      ready;
  logic [pfd_pkg::ChanW-1:0] roll_value;
  logic [pfd_pkg::ChanW-1:0] pitch_value;
  logic [pfd_pkg::ChanW-1:0] throttle_value;
  logic [pfd_pkg::ChanW-1:0] yaw_value;
  logic [pfd_pkg::ChanW-1:0] switch_value;
  logic [pfd_pkg::ChanW-1:0] mode_value;
  logic [1:0]                flight_mode;
  logic                      switch_on;

  modport source (
    output valid, output roll_value, output pitch_value, output throttle_value,
    output yaw_value, output switch_value, output mode_value, output flight_mode,
    output switch_on, input ready
  );
  modport sink (
    input valid, input roll_value, input pitch_value, input throttle_value,
    input yaw_value, input switch_value, input mode_value, input flight_mode,
    input switch_on, output ready
  );

endinterface

/* hdl/ppm_frame_decoder_core.sv */
// ----------------------------------------------------------------------------
// ppm_frame_decoder_core
// The closing edge word passes the input register, its frame word the result
//   register. Throughput: one edge word per cycle while the result slot is
//   free or drains; the per-edge path is a 32-bit subtract, a saturate and 16-bit compares.
// Reset: config registers take their defaults, decoder waits for sync with
//   last edge time zero; the channel buffer is not cleared.
// ----------------------------------------------------------------------------
module ppm_frame_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pfd_pkg::CfgDataW-1:0]  cfg_data_i,
  pfd_edge_if.sink                      in_edge,
  pfd_frame_if.source                   out_frame
);

  // configuration registers
  logic [pfd_pkg::ChanW-1:0] sync_thr_q, mode_hi_q, mode_lo_q, sw_thr_q;
  logic [pfd_pkg::ChanW-1:0] valid_min_q, valid_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_thr_q  <= pfd_pkg::SyncThresholdRst;
      mode_hi_q   <= pfd_pkg::ModeHighLimitRst;
      mode_lo_q   <= pfd_pkg::ModeLowLimitRst;
      sw_thr_q    <= pfd_pkg::SwitchThresholdRst;
      valid_min_q <= pfd_pkg::ValidMinRst;
      valid_max_q <= pfd_pkg::ValidMaxRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfd_pkg::CFG_SYNC_THRESHOLD:   sync_thr_q  <= cfg_data_i;
        pfd_pkg::CFG_MODE_HIGH_LIMIT:  mode_hi_q   <= cfg_data_i;
        pfd_pkg::CFG_MODE_LOW_LIMIT:   mode_lo_q   <= cfg_data_i;
        pfd_pkg::CFG_SWITCH_THRESHOLD: sw_thr_q    <= cfg_data_i;
        pfd_pkg::CFG_VALID_MIN:        valid_min_q <= cfg_data_i;
        pfd_pkg::CFG_VALID_MAX:        valid_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: the process stage moves when the result slot is free or drains
  logic in_valid_q;
  logic out_valid_q;
  logic advance;
  logic proc_fire;
  logic emit;

  assign advance       = !out_valid_q || out_frame.ready;
  assign in_edge.ready = !in_valid_q || advance;
  assign proc_fire     = in_valid_q && advance;

  // input register
  logic [pfd_pkg::TimeW-1:0] in_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_edge.ready) begin
      in_valid_q <= in_edge.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_edge.valid && in_edge.ready) begin
      in_time_q <= in_edge.edge_time_us;
    end
  end

  // decoder state
  logic [pfd_pkg::TimeW-1:0]  last_time_q;
  logic                       sync_seen_q;
  logic [pfd_pkg::CountW-1:0] count_q;
  logic [pfd_pkg::ChanW-1:0]  held_mode_q;
  logic [pfd_pkg::ChanW-1:0]  store_q [pfd_pkg::NumStored];

  // interval since the previous edge, wrapping, saturated to 16 bits
  logic [pfd_pkg::TimeW-1:0] diff;
  logic [pfd_pkg::ChanW-1:0] gap;
  logic                      is_sync;
  logic                      store_slot;
  logic                      mode_bad;
  logic [pfd_pkg::ChanW-1:0] mode_d;
  pfd_pkg::flight_mode_e     fm_d;
  logic                      sw_on_d;

  assign diff       = in_time_q - last_time_q;
  assign gap        = (|diff[pfd_pkg::TimeW-1:pfd_pkg::ChanW]) ? '1
                                                                : diff[pfd_pkg::ChanW-1:0];
  assign is_sync    = gap > sync_thr_q;
  assign store_slot = count_q < pfd_pkg::CountW'(pfd_pkg::NumStored);
  assign emit       = proc_fire && !is_sync && sync_seen_q && !store_slot;

  // mode channel: fall back on the held value when out of range
  assign mode_bad = (gap > valid_max_q) || (gap < valid_min_q);
  assign mode_d   = mode_bad ? held_mode_q : gap;
  assign sw_on_d  = store_q[pfd_pkg::NumStored-1] >= sw_thr_q;

  always_comb begin
    priority if (mode_d > mode_hi_q) begin
      fm_d = pfd_pkg::FM_HIGH;
    end else if (mode_d < mode_lo_q) begin
      fm_d = pfd_pkg::FM_LOW;
    end else begin
      fm_d = pfd_pkg::FM_MID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      sync_seen_q <= 1'b0;
      count_q     <= '0;
      held_mode_q <= '0;
    end else if (proc_fire) begin
      last_time_q <= in_time_q;
      if (is_sync) begin
        sync_seen_q <= 1'b1;
        count_q     <= '0;
      end else if (sync_seen_q) begin
        if (store_slot) begin
          count_q <= count_q + 1'b1;
        end else begin
          sync_seen_q <= 1'b0;
          count_q     <= '0;
          held_mode_q <= mode_d;
        end
      end
    end
  end

  // channel buffer, written in frame order
  always_ff @(posedge clk_i) begin
    if (proc_fire && !is_sync && sync_seen_q && store_slot) begin
      store_q[count_q] <= gap;
    end
  end

  // result register
  logic [pfd_pkg::ChanW-1:0] out_chan_q [pfd_pkg::NumStored];
  logic [pfd_pkg::ChanW-1:0] out_mode_q;
  pfd_pkg::flight_mode_e     out_fm_q;
  logic                      out_sw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_chan_q <= store_q;
      out_mode_q <= mode_d;
      out_fm_q   <= fm_d;
      out_sw_q   <= sw_on_d;
    end
  end

  assign out_frame.valid          = out_valid_q;
  assign out_frame.roll_value     = out_chan_q[0];
  assign out_frame.pitch_value    = out_chan_q[1];
  assign out_frame.throttle_value = out_chan_q[2];
  assign out_frame.yaw_value      = out_chan_q[3];
  assign out_frame.switch_value   = out_chan_q[4];
  assign out_frame.mode_value     = out_mode_q;
  assign out_frame.flight_mode    = out_fm_q;
  assign out_frame.switch_on      = out_sw_q;

  // checks
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pfd_pkg::CountW'(pfd_pkg::NumStored))
    else $error("channel count past buffer depth");

  a_count_needs_sync : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> sync_seen_q)
    else $error("channels counted without sync");

  a_emit_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (!sync_seen_q && count_q == '0))
    else $error("frame state not cleared after emit");

  a_out_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(emit))
    else $error("frame word without a closing edge");

  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_time_q)))
    else $error("stalled edge lost");

endmodule
